>>> hw/rtl/rch_pkg.sv
package rch_pkg;

    // counter width of one bin
    localparam int COUNT_BITS   = 32;
    localparam int REPORT_BITS  = 32;
    localparam int BYTE_BITS    = 8;
    localparam int CHAN_BITS    = 2;
    localparam int NUM_BINS     = 256;
    localparam int NUM_CHANNELS = 3;
    localparam int NUM_SLOTS    = NUM_CHANNELS * NUM_BINS;
    localparam int SLOT_BITS    = CHAN_BITS + BYTE_BITS;

    // channel codes
    localparam logic [CHAN_BITS-1:0] CHAN_BLUE = 2'd0;
    localparam logic [CHAN_BITS-1:0] CHAN_RED  = 2'd2;
    localparam logic [CHAN_BITS-1:0] CHAN_NONE = 2'd3;

    // action codes
    typedef enum logic [1:0] {
        ACT_COUNT   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    typedef logic [COUNT_BITS-1:0] count_t;

    // one result item
    typedef struct packed {
        logic [BYTE_BITS-1:0]   read_bin;
        logic [CHAN_BITS-1:0]   read_channel;
        logic [REPORT_BITS-1:0] bin_count;
    } result_t;

    // clamp a stored count to the reported width
    function automatic logic [REPORT_BITS-1:0] report_count(input count_t value);
        logic [63:0] wide;
        wide = 64'(value);
        if (wide > 64'(REPORT_BITS'('1)))
            return '1;
        return wide[REPORT_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/rgb_channel_histogram.sv
// channel   dir  handshake               payload
// s_axis    in   tvalid / tready         tdata: data_byte; tuser: action, channel
// m_axis    out  tvalid / tready         tdata: bin_count, read_bin; tuser: read_channel
//
// count and restart items one per cycle when ready; a count: RAM bin read, modify, write back
// a write in the same cycle as the next read of that bin is forwarded
// a read result goes via stage one to the main output entry; unstalled reads run two in three
// after reset a clearing pass zeroes all 768 bins, one per cycle; no item is taken then
// results wait in a two-entry output buffer; tready drops while two results are pending,
// counting one still in the read stage
// count and restart items give no result
module rgb_channel_histogram (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic [3:0]                     s_axis_tuser,   // [1:0] action, [3:2] channel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rch_pkg::REPORT_BITS+rch_pkg::BYTE_BITS-1:0] m_axis_tdata,
                                           // [31:0] bin_count, [39:32] read_bin
    output logic [rch_pkg::CHAN_BITS-1:0]  m_axis_tuser    // [1:0] read_channel
);

    import rch_pkg::*;

    typedef enum logic [1:0] {
        OP_COUNT,
        OP_READ,
        OP_CLEAR
    } op_t;

    // control registers
    logic                  clearing_reg,  clearing_next;
    logic [SLOT_BITS-1:0]  clr_cnt_reg,   clr_cnt_next;
    logic [CHAN_BITS-1:0]  phase_reg,     phase_next;
    logic                  s1_valid_reg,  s1_valid_next;
    op_t                   s1_op_reg,     s1_op_next;
    logic [SLOT_BITS-1:0]  s1_addr_reg,   s1_addr_next;
    logic                  fwd_valid_reg, fwd_valid_next;
    logic [SLOT_BITS-1:0]  fwd_addr_reg,  fwd_addr_next;
    count_t                fwd_data_reg,  fwd_data_next;
    logic                  main_valid_reg, main_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    result_t               main_reg,      main_next;
    result_t               skid_reg,      skid_next;

    // input decode
    logic                  in_accept;
    action_t               in_action;
    logic [CHAN_BITS-1:0]  in_chan;
    logic [BYTE_BITS-1:0]  in_byte;
    logic [CHAN_BITS-1:0]  phase_eff;
    logic [CHAN_BITS-1:0]  sel_chan;

    // memory ports
    logic                  ram_we;
    logic [SLOT_BITS-1:0]  ram_waddr;
    count_t                ram_wdata;
    logic [SLOT_BITS-1:0]  ram_raddr;
    count_t                ram_rdata;

    // stage one
    count_t                cur_count;
    logic                  s1_write;
    count_t                s1_wdata;
    logic                  s1_push;
    result_t               s1_result;
    logic                  out_pop;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_action = action_t'(s_axis_tuser[1:0]);
    assign in_chan   = s_axis_tuser[3:2];
    assign in_byte   = s_axis_tdata;
    assign phase_eff = (phase_reg == CHAN_NONE) ? CHAN_BLUE : phase_reg;

    // room for one more result, counting the one in flight
    assign s_axis_tready = !clearing_reg
                           && !(main_valid_reg && skid_valid_reg)
                           && !(main_valid_reg && s1_push)
                           && !(skid_valid_reg && s1_push);

    // bin address of the incoming item
    always_comb
    begin
        if (in_action == ACT_COUNT)
            sel_chan = phase_eff;
        else if (in_chan == CHAN_NONE)
            sel_chan = CHAN_BLUE;
        else
            sel_chan = in_chan;
    end

    assign ram_raddr = {sel_chan, in_byte};

    // phase and stage one capture
    always_comb
    begin
        phase_next    = phase_reg;
        s1_valid_next = 1'b0;
        s1_op_next    = s1_op_reg;
        s1_addr_next  = ram_raddr;
        if (in_accept)
        begin
            case (in_action)
                ACT_COUNT:
                begin
                    phase_next    = (phase_eff == CHAN_RED) ? CHAN_BLUE
                                                            : phase_eff + CHAN_BITS'(1);
                    s1_valid_next = 1'b1;
                    s1_op_next    = OP_COUNT;
                end
                ACT_READ:
                begin
                    s1_valid_next = (in_chan != CHAN_NONE);
                    s1_op_next    = OP_READ;
                end
                ACT_CLEAR:
                begin
                    s1_valid_next = (in_chan != CHAN_NONE);
                    s1_op_next    = OP_CLEAR;
                end
                ACT_RESTART:
                begin
                    phase_next = CHAN_BLUE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // modify: forwarded or stored count
    assign cur_count = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg
                                                                      : ram_rdata;

    always_comb
    begin
        s1_write = 1'b0;
        s1_wdata = cur_count;
        s1_push  = 1'b0;
        if (s1_valid_reg)
        begin
            case (s1_op_reg)
                OP_COUNT:
                begin
                    s1_write = 1'b1;
                    s1_wdata = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);
                end
                OP_READ:
                begin
                    s1_push = 1'b1;
                end
                OP_CLEAR:
                begin
                    s1_push  = 1'b1;
                    s1_write = 1'b1;
                    s1_wdata = '0;
                end
                default:
                begin
                    s1_push = 1'b0;
                end
            endcase
        end
    end

    assign s1_result.bin_count    = report_count(cur_count);
    assign s1_result.read_channel = s1_addr_reg[SLOT_BITS-1:BYTE_BITS];
    assign s1_result.read_bin     = s1_addr_reg[BYTE_BITS-1:0];

    // write port: clearing pass or write-back
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_write;
            ram_waddr = s1_addr_reg;
            ram_wdata = s1_wdata;
        end
    end

    assign fwd_valid_next = s1_write && !clearing_reg;
    assign fwd_addr_next  = s1_addr_reg;
    assign fwd_data_next  = s1_wdata;

    // clearing pass
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            if (clr_cnt_reg == SLOT_BITS'(NUM_SLOTS - 1))
                clearing_next = 1'b0;
            else
                clr_cnt_next = clr_cnt_reg + SLOT_BITS'(1);
        end
    end

    // output buffer: main entry plus skid entry
    assign out_pop = main_valid_reg && m_axis_tready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (out_pop)
        begin
            main_valid_next = skid_valid_reg;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (s1_push)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_next       = s1_result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = s1_result;
            end
        end
    end

    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tdata  = {main_reg.read_bin, main_reg.bin_count};
    assign m_axis_tuser  = main_reg.read_channel;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            phase_reg      <= CHAN_BLUE;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clr_cnt_reg    <= clr_cnt_next;
            phase_reg      <= phase_next;
            s1_valid_reg   <= s1_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        s1_op_reg    <= s1_op_next;
        s1_addr_reg  <= s1_addr_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
        main_reg     <= main_next;
        skid_reg     <= skid_next;
    end

    rch_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a result never arrives at a full buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_push |-> !(main_valid_reg && skid_valid_reg))
        else $error("result pushed into full output buffer");

    // skid entry only fills behind the main entry
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid while main entry empty");

    // no item in flight during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg && !main_valid_reg)
        else $error("item in flight during clearing pass");

    // clearing address stays inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> clr_cnt_reg < SLOT_BITS'(NUM_SLOTS))
        else $error("clearing address out of range");

    // a result pushed into an empty output buffer shows up the cycle after
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_push && !out_pop && !main_valid_reg |=> main_valid_reg)
        else $error("result lost on its way to the output");

endmodule

>>> hw/rtl/rch_ram.sv
module rch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
